### hw/rtl/kbcs_pkg.sv
// Shared types, constants and tables of the kernel best cluster select unit.
package kbcs_pkg;

	localparam int VALUE_W = 16;
	localparam int LABEL_W = 16;
	localparam int SCALE_W = 24;
	localparam int ALPHA_W = 17;
	localparam int SCORE_W = 17;
	localparam int FSUM_W  = 40;
	localparam int CSUM_W  = 35;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [1:0] MODE_FEATURE = 2'd0;
	localparam logic [1:0] MODE_COORD   = 2'd1;
	localparam logic [1:0] MODE_CAND    = 2'd2;
	localparam logic [1:0] MODE_VOXEL   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_DATA_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COORD_SCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 2'd2;

	localparam logic [SCALE_W-1:0] DATA_SCALE_RST  = 24'd65536;
	localparam logic [SCALE_W-1:0] COORD_SCALE_RST = 24'd65536;
	localparam logic [ALPHA_W-1:0] ALPHA_RST       = 17'd32768;
	localparam logic [ALPHA_W-1:0] ONE_Q16         = 17'd65536;

	localparam logic [31:0] LN2_Q32     = 32'd2977044472;
	localparam logic [43:0] EXP_ZERO_AT = 44'd786432;
	localparam logic [3:0]  SERIES_LAST = 4'd10;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [VALUE_W-1:0] voxel_value;
		logic signed [VALUE_W-1:0] centroid_value;
		logic [LABEL_W-1:0] label;
	} in_item_t;

	typedef struct packed {
		logic [LABEL_W-1:0] best_label;
		logic               switched;
		logic [SCORE_W-1:0] best_score;
		logic [15:0]        switch_count;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_write_t;

	// floor(2^32 / k) for the series divisors
	function automatic logic [31:0] recip_k(input logic [3:0] k);
		logic [31:0] m;
		unique case (k)
			4'd2:    m = 32'd2147483648;
			4'd3:    m = 32'd1431655765;
			4'd4:    m = 32'd1073741824;
			4'd5:    m = 32'd858993459;
			4'd6:    m = 32'd715827882;
			4'd7:    m = 32'd613566756;
			4'd8:    m = 32'd536870912;
			4'd9:    m = 32'd477218588;
			4'd10:   m = 32'd429496729;
			default: m = 32'd0;
		endcase
		return m;
	endfunction

endpackage

### hw/rtl/kbcs_if.sv
// Channel interfaces of the kernel best cluster select unit.
interface kbcs_in_if;
	kbcs_pkg::in_item_t data;
	logic valid;
	logic ready;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface kbcs_out_if;
	kbcs_pkg::out_item_t data;
	logic valid;
	logic ready;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface kbcs_cfg_if;
	kbcs_pkg::cfg_write_t data;
	logic valid;
	logic ready;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/kbcs_mult.sv
// Shared registered multiplier of the kernel best cluster select unit.
module kbcs_mult (
	input  logic        clk,
	input  logic [32:0] op_a,
	input  logic [31:0] op_b,
	output logic [64:0] prod
);
	logic [64:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 65'(op_a) * 65'(op_b);
	end

	assign prod = prod_q;
endmodule

### hw/rtl/kbcs_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module kbcs_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [50:0] operand,
	output logic [25:0] root,
	output logic        done
);
	logic [51:0] rem_q;
	logic [51:0] res_q;
	logic [50:0] bit_q;
	logic        busy_q;
	logic [51:0] trial;

	assign trial = res_q + 52'(bit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 52'(operand);
			res_q <= '0;
			bit_q <= 51'(1) << 50;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + 52'(bit_q);
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[25:0];
	assign done = !busy_q;
endmodule

### hw/rtl/kernel_best_cluster_select_unit.sv
// Top level of the kernel best cluster select unit.
// Input items arrive on in_ch (valid/ready). Mode 0 and mode 1 items add one
// squared element difference to the feature or coordinate sum; mode 2 closes
// a candidate and scores it with a Gaussian kernel of the feature sum and
// an exponential kernel of the coordinate distance; mode 3 ends a voxel and
// sends one item on out_ch. Registers are written on cfg_ch, which is always
// ready; write them only while the unit is idle. Mode 0/1 items square the
// difference on the shared multiplier, then do a saturating add. Mode 2
// computes two exponentials, each a range reduction of up to 23 subtract
// steps plus a ten-term series (per term a multiply by the reduced argument,
// then a division by k through a reciprocal multiply and correction), then
// weights them; the square root runs beside the first exponential. All
// products use the one shared multiplier; mode 3 waits until out_ch is free.
// The finished result sits in an output register; the unit accepts further
// items while it waits, and a second voxel end holds until out_ch takes it.
// Reset clears all sums, the leader, the candidate count, the switch counter
// and restores the register defaults.
module kernel_best_cluster_select_unit (
	input  logic clk,
	input  logic arst_n,
	kbcs_in_if.sink    in_ch,
	kbcs_out_if.source out_ch,
	kbcs_cfg_if.sink   cfg_ch
);
	import kbcs_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE = 16'h0001,
		S_SQ   = 16'h0002,
		S_ACC  = 16'h0004,
		S_T1   = 16'h0008,
		S_T1W  = 16'h0010,
		S_DIVN = 16'h0020,
		S_TM   = 16'h0040,
		S_TD   = 16'h0080,
		S_TQ   = 16'h0100,
		S_EXPF = 16'h0200,
		S_T2   = 16'h0400,
		S_T2W  = 16'h0800,
		S_SC1  = 16'h1000,
		S_SC2  = 16'h2000,
		S_SC3  = 16'h4000,
		S_VOX  = 16'h8000
	} state_t;

	state_t state_q;

	logic [SCALE_W-1:0] data_scale_q;
	logic [SCALE_W-1:0] coord_scale_q;
	logic [ALPHA_W-1:0] alpha_q;

	logic [1:0]         mode_q;
	logic [VALUE_W-1:0] vox_q;
	logic [VALUE_W-1:0] cen_q;
	logic [LABEL_W-1:0] label_q;

	logic [FSUM_W-1:0]  fsum_q;
	logic [CSUM_W-1:0]  csum_q;
	logic [SCORE_W-1:0] lead_score_q;
	logic [LABEL_W-1:0] lead_label_q;
	logic [1:0]         cand_q;
	logic [15:0]        sw_total_q;

	logic        tbig_q;
	logic [35:0] ebig_q;
	logic [4:0]  n_q;
	logic [31:0] r_q;
	logic [33:0] a_q;
	logic [32:0] term_q;
	logic [31:0] p_q;
	logic [3:0]  k_q;
	logic [16:0] e1_q;
	logic [16:0] e2_q;
	logic        which_q;
	logic [32:0] wsum_q;

	logic      out_valid_q;
	out_item_t out_q;

	logic        in_acc;
	logic        out_load;
	logic [32:0] mul_a;
	logic [31:0] mul_b;
	logic [64:0] prod;
	logic        sq_start;
	logic [25:0] root;
	logic        root_done;

	logic [VALUE_W:0] diff;
	logic [VALUE_W:0] absd;
	logic [ALPHA_W-1:0] alpha_sat;
	logic [FSUM_W:0]  fsum_nx;
	logic [CSUM_W:0]  csum_nx;
	logic [32:0]  p_full;
	logic [31:0]  q_est;
	logic [35:0]  q_rem;
	logic [31:0]  q_fin;
	logic [5:0]   shamt;
	logic [34:0]  rnd_sum;
	logic [34:0]  exp_val;
	logic [43:0]  t1;
	logic [41:0]  t2;
	logic [32:0]  score_sum;
	logic [SCORE_W-1:0] score;
	logic         sw;

	assign in_ch.ready  = (state_q == S_IDLE);
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;
	assign sq_start     = in_acc && (in_ch.data.mode == MODE_CAND);
	assign out_load     = (state_q == S_VOX) && (!out_valid_q || out_ch.ready);

	kbcs_mult u_mult (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	kbcs_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand ({csum_q, 16'b0}),
		.root    (root),
		.done    (root_done)
	);

	always_comb begin
		diff      = {vox_q[VALUE_W-1], vox_q} - {cen_q[VALUE_W-1], cen_q};
		absd      = diff[VALUE_W] ? (~diff + 1'b1) : diff;
		alpha_sat = (alpha_q > ONE_Q16) ? ONE_Q16 : alpha_q;
		fsum_nx   = {1'b0, fsum_q} + (FSUM_W+1)'(prod[33:0]);
		csum_nx   = {1'b0, csum_q} + (CSUM_W+1)'(prod[33:0]);
		p_full    = prod[64:32];
		q_est     = prod[63:32];
		q_rem     = 36'(p_q) - 36'(q_est) * 36'(k_q);
		q_fin     = (q_rem >= 36'(k_q)) ? q_est + 32'd1 : q_est;
		shamt     = 6'(n_q) + 6'd16;
		rnd_sum   = 35'(a_q) + (35'(1) << (6'(n_q) + 6'd15));
		exp_val   = rnd_sum >> shamt;
		t1        = prod[43:0];
		t2        = prod[49:8];
		score_sum = wsum_q + prod[32:0];
		score     = score_sum[32:16];
		sw        = lead_label_q != label_q;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ: begin
				mul_a = 33'(absd);
				mul_b = 32'(absd);
			end
			S_T1: begin
				mul_a = 33'(fsum_q[19:0]);
				mul_b = 32'(data_scale_q);
			end
			S_TM: begin
				mul_a = term_q;
				mul_b = r_q;
			end
			S_TD: begin
				mul_a = p_full;
				mul_b = recip_k(k_q);
			end
			S_T2: begin
				mul_a = 33'(root);
				mul_b = 32'(coord_scale_q);
			end
			S_SC1: begin
				mul_a = 33'(alpha_sat);
				mul_b = 32'(e1_q);
			end
			S_SC2: begin
				mul_a = 33'(ONE_Q16 - alpha_sat);
				mul_b = 32'(e2_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_scale_q  <= DATA_SCALE_RST;
			coord_scale_q <= COORD_SCALE_RST;
			alpha_q       <= ALPHA_RST;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			unique case (cfg_ch.data.index)
				REG_DATA_SCALE:  data_scale_q  <= cfg_ch.data.value;
				REG_COORD_SCALE: coord_scale_q <= cfg_ch.data.value;
				REG_ALPHA:       alpha_q       <= cfg_ch.data.value[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q  <= in_ch.data.mode;
			vox_q   <= in_ch.data.voxel_value;
			cen_q   <= in_ch.data.centroid_value;
			label_q <= in_ch.data.label;
		end
		if (out_load) begin
			if (cand_q < 2'd2) begin
				out_q.best_label   <= label_q;
				out_q.switched     <= 1'b0;
				out_q.best_score   <= '0;
				out_q.switch_count <= sw_total_q;
			end else begin
				out_q.best_label   <= lead_label_q;
				out_q.switched     <= sw;
				out_q.best_score   <= lead_score_q;
				out_q.switch_count <= (sw && sw_total_q != 16'hFFFF) ?
					sw_total_q + 16'd1 : sw_total_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_T1W: begin
				tbig_q  <= (fsum_q[39:20] != '0 && data_scale_q != '0) ||
					(t1 >= EXP_ZERO_AT);
				ebig_q  <= {t1[19:0], 16'b0};
				n_q     <= '0;
				which_q <= 1'b0;
			end
			S_T2W: begin
				tbig_q  <= 44'(t2) >= EXP_ZERO_AT;
				ebig_q  <= {t2[19:0], 16'b0};
				n_q     <= '0;
				which_q <= 1'b1;
			end
			S_DIVN: begin
				if (ebig_q >= 36'(LN2_Q32)) begin
					ebig_q <= ebig_q - 36'(LN2_Q32);
					n_q    <= n_q + 5'd1;
				end else begin
					r_q    <= ebig_q[31:0];
					a_q    <= 34'(1) << 32;
					term_q <= 33'(1) << 32;
					k_q    <= 4'd1;
				end
			end
			S_TD: begin
				p_q <= p_full[31:0];
				if (k_q == 4'd1) begin
					term_q <= p_full;
					a_q    <= a_q - 34'(p_full);
					k_q    <= k_q + 4'd1;
				end
			end
			S_TQ: begin
				term_q <= 33'(q_fin);
				a_q    <= k_q[0] ? a_q - 34'(q_fin) : a_q + 34'(q_fin);
				k_q    <= k_q + 4'd1;
			end
			S_EXPF: begin
				if (which_q) begin
					e2_q <= tbig_q ? '0 : exp_val[16:0];
				end else begin
					e1_q <= tbig_q ? '0 : exp_val[16:0];
				end
			end
			S_SC2: begin
				wsum_q <= prod[32:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fsum_q       <= '0;
			csum_q       <= '0;
			lead_score_q <= '0;
			lead_label_q <= '0;
			cand_q       <= '0;
			sw_total_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (in_ch.data.mode)
							MODE_FEATURE, MODE_COORD: state_q <= S_SQ;
							MODE_CAND:                state_q <= S_T1;
							MODE_VOXEL:               state_q <= S_VOX;
							default:                  state_q <= S_IDLE;
						endcase
					end
				end
				S_SQ: state_q <= S_ACC;
				S_ACC: begin
					if (mode_q == MODE_FEATURE) begin
						fsum_q <= fsum_nx[FSUM_W] ? '1 : fsum_nx[FSUM_W-1:0];
					end else begin
						csum_q <= csum_nx[CSUM_W] ? '1 : csum_nx[CSUM_W-1:0];
					end
					state_q <= S_IDLE;
				end
				S_T1:  state_q <= S_T1W;
				S_T1W: state_q <= S_DIVN;
				S_DIVN: begin
					if (ebig_q < 36'(LN2_Q32)) begin
						state_q <= S_TM;
					end
				end
				S_TM: state_q <= S_TD;
				S_TD: state_q <= (k_q == 4'd1) ? S_TM : S_TQ;
				S_TQ: state_q <= (k_q == SERIES_LAST) ? S_EXPF : S_TM;
				S_EXPF: state_q <= which_q ? S_SC1 : S_T2;
				S_T2: begin
					if (root_done) begin
						state_q <= S_T2W;
					end
				end
				S_T2W: state_q <= S_DIVN;
				S_SC1: state_q <= S_SC2;
				S_SC2: state_q <= S_SC3;
				S_SC3: begin
					if (cand_q == 2'd0 || score > lead_score_q) begin
						lead_score_q <= score;
						lead_label_q <= label_q;
					end
					if (cand_q < 2'd2) begin
						cand_q <= cand_q + 2'd1;
					end
					fsum_q  <= '0;
					csum_q  <= '0;
					state_q <= S_IDLE;
				end
				S_VOX: begin
					if (out_load) begin
						if (cand_q == 2'd2 && sw && sw_total_q != 16'hFFFF) begin
							sw_total_q <= sw_total_q + 16'd1;
						end
						lead_score_q <= '0;
						lead_label_q <= '0;
						cand_q       <= '0;
						fsum_q       <= '0;
						csum_q       <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### test/tb_kernel_best_cluster_select_unit.sv
// Self-checking testbench of the kernel best cluster select unit.
module tb_kernel_best_cluster_select_unit;
	import kbcs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	kbcs_in_if  in_ch();
	kbcs_out_if out_ch();
	kbcs_cfg_if cfg_ch();

	kernel_best_cluster_select_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [SCALE_W-1:0] m_dscale, m_cscale;
	logic [ALPHA_W-1:0] m_alpha;
	logic [FSUM_W-1:0] m_fsum;
	logic [CSUM_W-1:0] m_csum;
	logic [SCORE_W-1:0] m_lead_score;
	logic [LABEL_W-1:0] m_lead_label;
	int m_seen;
	logic [15:0] m_switches;

	out_item_t pending_q[$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int voxels_sent = 0;
	int out_wait = 0;
	longint cycles = 0;
	localparam longint CYCLE_LIMIT = 64'd3000000;

	function automatic logic [63:0] sq_of(logic signed [15:0] a, logic signed [15:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0) d = -d;
		return d * d;
	endfunction

	function automatic logic [63:0] neg_exp(logic [63:0] t);
		logic [63:0] big, n, r, a, term;
		logic [127:0] p;
		if (t >= 64'd786432) return 0;
		big = t << 16;
		n = big / 64'd2977044472;
		r = big - n * 64'd2977044472;
		a = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int k = 1; k <= 10; k++) begin
			p = 128'(term) * 128'(r);
			term = 64'((p >> 32) / 128'(k));
			if (k % 2 == 1) a -= term;
			else a += term;
		end
		return (a + (64'd1 << (15 + n))) >> (16 + n);
	endfunction

	function automatic logic [63:0] int_root(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] kernel_score();
		logic [63:0] e1, e2, root, a;
		e1 = neg_exp(64'(m_fsum) * 64'(m_dscale));
		root = int_root(64'(m_csum) << 16);
		e2 = neg_exp((root * 64'(m_cscale)) >> 8);
		a = (m_alpha > ONE_Q16) ? 64'd65536 : 64'(m_alpha);
		return (a * e1 + (64'd65536 - a) * e2) >> 16;
	endfunction

	task automatic predict_item(input in_item_t it);
		logic [63:0] x, s;
		out_item_t o;
		case (it.mode)
			MODE_FEATURE: begin
				x = sq_of(it.voxel_value, it.centroid_value);
				if (x >= {24'd0, FSUM_W'('1)} || 64'(m_fsum) > 64'(FSUM_W'('1)) - x)
					m_fsum = '1;
				else
					m_fsum = FSUM_W'(64'(m_fsum) + x);
			end
			MODE_COORD: begin
				x = sq_of(it.voxel_value, it.centroid_value);
				if (x >= 64'(CSUM_W'('1)) || 64'(m_csum) > 64'(CSUM_W'('1)) - x)
					m_csum = '1;
				else
					m_csum = CSUM_W'(64'(m_csum) + x);
			end
			MODE_CAND: begin
				s = kernel_score();
				if (m_seen == 0 || s > 64'(m_lead_score)) begin
					m_lead_score = SCORE_W'(s);
					m_lead_label = it.label;
				end
				if (m_seen < 2) m_seen++;
				m_fsum = '0;
				m_csum = '0;
			end
			default: begin
				if (m_seen < 2) begin
					o.best_label = it.label;
					o.switched = 1'b0;
					o.best_score = '0;
				end else begin
					o.best_label = m_lead_label;
					o.switched = (m_lead_label != it.label);
					o.best_score = m_lead_score;
					if (o.switched && m_switches != 16'hFFFF) m_switches++;
				end
				o.switch_count = m_switches;
				pending_q = {pending_q, o};
				m_lead_score = '0;
				m_lead_label = '0;
				m_seen = 0;
				m_fsum = '0;
				m_csum = '0;
			end
		endcase
	endtask

	task automatic send_item(input in_item_t it);
		int gap;
		gap = $urandom_range(0, 17);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.data <= it;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		predict_item(it);
		items_sent++;
		if (it.mode == MODE_VOXEL) voxels_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		cfg_ch.data <= '{index: idx, value: v};
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_DATA_SCALE:  m_dscale = v;
			REG_COORD_SCALE: m_cscale = v;
			REG_ALPHA:       m_alpha = v[ALPHA_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic in_item_t mk(logic [1:0] m, int v, int c, int l);
		in_item_t it;
		it.mode = m;
		it.voxel_value = VALUE_W'(v);
		it.centroid_value = VALUE_W'(c);
		it.label = LABEL_W'(l);
		return it;
	endfunction

	function automatic logic signed [15:0] rand_val();
		case ($urandom_range(0, 3))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'(int'($urandom_range(0, 63)) - 32);
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic random_voxel();
		int ncand, nel;
		logic [15:0] lab;
		ncand = $urandom_range(0, 4);
		for (int c = 0; c < ncand; c++) begin
			nel = $urandom_range(0, 5);
			for (int e = 0; e < nel; e++)
				send_item(mk(2'($urandom_range(0, 1)), rand_val(), rand_val(),
					$urandom()));
			lab = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 3)) : 16'($urandom());
			send_item(mk(MODE_CAND, rand_val(), rand_val(), lab));
		end
		if ($urandom_range(0, 4) == 0)
			send_item(mk(2'($urandom_range(0, 1)), rand_val(), rand_val(), $urandom()));
		send_item(mk(MODE_VOXEL, rand_val(), rand_val(),
			($urandom_range(0, 1)) ? $urandom_range(0, 3) : $urandom()));
	endtask

	// directed table; has_exp marks rows with a typed-in result
	typedef struct {
		in_item_t it;
		bit has_exp;
		out_item_t exp_out;
	} dir_row_t;

	dir_row_t dir_table[] = '{
		'{mk(MODE_VOXEL, 0, 0, 16'h1234), 1, '{16'h1234, 1'b0, 17'd0, 16'd0}},
		'{mk(MODE_CAND, 0, 0, 5), 0, '0},
		'{mk(MODE_VOXEL, 0, 0, 16'hFFFF), 1, '{16'hFFFF, 1'b0, 17'd0, 16'd0}},
		'{mk(MODE_CAND, 0, 0, 7), 0, '0},
		'{mk(MODE_CAND, 0, 0, 9), 0, '0},
		'{mk(MODE_VOXEL, 0, 0, 7), 1, '{16'd7, 1'b0, 17'd65536, 16'd0}},
		'{mk(MODE_FEATURE, 32767, -32768, 0), 0, '0},
		'{mk(MODE_FEATURE, 32767, -32768, 0), 0, '0},
		'{mk(MODE_COORD, -32768, 32767, 0), 0, '0},
		'{mk(MODE_CAND, 0, 0, 16'hFFFF), 0, '0},
		'{mk(MODE_COORD, 3, 1, 0), 0, '0},
		'{mk(MODE_CAND, 0, 0, 16'h00AA), 0, '0},
		'{mk(MODE_VOXEL, 0, 0, 1), 0, '0},
		'{mk(MODE_FEATURE, 1, 0, 0), 0, '0},
		'{mk(MODE_CAND, 0, 0, 3), 0, '0},
		'{mk(MODE_FEATURE, 2, 0, 0), 0, '0},
		'{mk(MODE_CAND, 0, 0, 4), 0, '0},
		'{mk(MODE_COORD, 100, -100, 0), 0, '0},
		'{mk(MODE_VOXEL, 0, 0, 3), 0, '0},
		'{mk(MODE_CAND, 0, 0, 2), 0, '0},
		'{mk(MODE_CAND, 0, 0, 4), 0, '0},
		'{mk(MODE_FEATURE, 5, 5, 0), 0, '0},
		'{mk(MODE_VOXEL, 0, 0, 4), 0, '0}
	};

	// output side: random stalls and checking
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_wait = $urandom_range(0, 17);
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				out_item_t e;
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_ch.data);
					errors++;
				end else begin
					e = pending_q.pop_front();
					if (out_ch.data.best_label !== e.best_label ||
					    out_ch.data.switched !== e.switched ||
					    out_ch.data.best_score !== e.best_score ||
					    out_ch.data.switch_count !== e.switch_count) begin
						$display("%0t: expected %p actual %p", $time, e, out_ch.data);
						errors++;
					end
				end
				results_seen++;
				out_wait = $urandom_range(0, 17);
			end
			if (out_wait == 0) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b0;
				out_wait--;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		m_dscale = DATA_SCALE_RST;
		m_cscale = COORD_SCALE_RST;
		m_alpha = ALPHA_RST;
		m_fsum = '0;
		m_csum = '0;
		m_lead_score = '0;
		m_lead_label = '0;
		m_seen = 0;
		m_switches = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			send_item(dir_table[i].it);
			if (dir_table[i].has_exp) begin
				out_item_t p;
				p = pending_q[$];
				if (p !== dir_table[i].exp_out) begin
					$display("%0t: table row %0d expected %p actual %p",
						$time, i, dir_table[i].exp_out, p);
					errors++;
				end
			end
		end
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_DATA_SCALE, 24'd0);
					write_reg(REG_COORD_SCALE, 24'hFFFFFF);
					write_reg(REG_ALPHA, 24'd0);
				end
				1: begin
					write_reg(REG_DATA_SCALE, 24'hFFFFFF);
					write_reg(REG_COORD_SCALE, 24'd0);
					write_reg(REG_ALPHA, 24'd65536);
				end
				2: begin
					write_reg(REG_DATA_SCALE, 24'd1);
					write_reg(REG_COORD_SCALE, 24'd16);
					write_reg(REG_ALPHA, 24'h1FFFF);
				end
				3: write_reg(REG_NONE, CFG_DATA_W'($urandom()));
				default: begin
					write_reg(REG_DATA_SCALE, CFG_DATA_W'($urandom_range(0, 200)));
					write_reg(REG_COORD_SCALE, CFG_DATA_W'($urandom_range(0, 4096)));
					write_reg(REG_ALPHA, CFG_DATA_W'($urandom_range(0, 65536)));
				end
			endcase
			while (items_sent < 25 + (phase + 1) * 225) random_voxel();
			drain();
		end

		$display("%0d items, %0d voxels, %0d results checked over six register settings",
			items_sent, voxels_sent, results_seen);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

### kernel_best_cluster_select_unit.f
hw/rtl/kbcs_pkg.sv
hw/rtl/kbcs_if.sv
hw/rtl/kbcs_mult.sv
hw/rtl/kbcs_isqrt.sv
hw/rtl/kernel_best_cluster_select_unit.sv
test/tb_kernel_best_cluster_select_unit.sv
